/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// General check, sampled on the rising clock and off while reset is held.
`define FHM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Same-cycle implication.
`define FHM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`endif

/* hw/rtl/fhm_pkg.sv */
package fhm_pkg;

    localparam int SINE_TABLE_BITS_DEF = 9;
    localparam int CORDIC_STEPS_DEF    = 16;

    localparam int DIV_W = 34;   // dividend and quotient width
    localparam int CW    = 34;   // CORDIC x/y width
    localparam int ZW    = 27;   // CORDIC angle width, Q16 degrees

    localparam logic [16:0] DEG_Q8_FULL        = 17'd92160;
    localparam logic signed [ZW-1:0] DEG_Q16_QUARTER = 27'sd5898240;
    localparam logic signed [ZW-1:0] DEG_Q16_HALF    = 27'sd11796480;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032875;
    localparam logic [18:0] RECIP_45_Q24 = 19'd372828;

    localparam logic [11:0] ROTATION_GAIN_RST     = 12'd486;
    localparam logic [7:0]  ROTATION_DEADBAND_RST = 8'd18;
    localparam logic [6:0]  MOVE_DEADBAND_RST     = 7'd25;
    localparam logic [15:0] COUNTS_PER_TURN_RST   = 16'd15400;
    localparam logic [8:0]  MIX_MOVE_SHARE_RST    = 9'd192;
    localparam logic [8:0]  MIX_ROTATE_SHARE_RST  = 9'd64;

    typedef enum logic [2:0] {
        CFG_ROTATION_GAIN     = 3'd0,
        CFG_ROTATION_DEADBAND = 3'd1,
        CFG_MOVE_DEADBAND     = 3'd2,
        CFG_COUNTS_PER_TURN   = 3'd3,
        CFG_MIX_MOVE_SHARE    = 3'd4,
        CFG_MIX_ROTATE_SHARE  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic rmul;
        logic div2_start;
        logic head;
        logic idx;
        logic ang;
        logic mix1;
        logic mix2;
        logic mix3;
        logic out_load;
    } fhm_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic cordic_busy;
        logic out_free;
    } fhm_status_t;

    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = 27'sd2949120;
            1:       a = 27'sd1740967;
            2:       a = 27'sd919879;
            3:       a = 27'sd466945;
            4:       a = 27'sd234379;
            5:       a = 27'sd117304;
            6:       a = 27'sd58666;
            7:       a = 27'sd29335;
            8:       a = 27'sd14668;
            9:       a = 27'sd7334;
            10:      a = 27'sd3667;
            11:      a = 27'sd1833;
            12:      a = 27'sd917;
            13:      a = 27'sd458;
            14:      a = 27'sd229;
            15:      a = 27'sd115;
            16:      a = 27'sd57;
            17:      a = 27'sd29;
            18:      a = 27'sd14;
            19:      a = 27'sd7;
            20:      a = 27'sd4;
            21:      a = 27'sd2;
            22:      a = 27'sd1;
            default: a = 27'sd0;
        endcase
        return a;
    endfunction

endpackage

/* hw/rtl/fhm_div.sv */
module fhm_div import fhm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [15:0]      divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient,
    output logic [15:0]      remainder
);

    localparam int CNTW = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [16:0]      rem_reg, rem_next;
    logic [15:0]      dvs_reg, dvs_next;
    logic [16:0]      rem_sh;

    // One quotient bit per cycle, restoring form.
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg[15:0], quo_reg[DIV_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(DIV_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[15:0];

endmodule

/* hw/rtl/fhm_cordic.sv */
module fhm_cordic import fhm_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic                 vectoring,
    input  logic signed [CW-1:0] x_init,
    input  logic signed [CW-1:0] y_init,
    input  logic signed [ZW-1:0] z_init,
    output logic                 busy,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);

    localparam int ITW = $clog2(STEPS + 1);

    logic                 busy_reg, busy_next;
    logic [ITW-1:0]       iter_reg, iter_next;
    logic                 vec_reg, vec_next;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] a;
    logic                 pos;

    always_comb begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        vec_next  = vec_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        xs        = x_reg >>> iter_reg;
        ys        = y_reg >>> iter_reg;
        a         = atan_q16(int'(iter_reg));
        // positive micro-rotation: drives y up in vectoring, z down in rotation
        pos       = vec_reg ? !(y_reg > 0) : (z_reg >= 0);
        if (start) begin
            busy_next = 1'b1;
            iter_next = '0;
            vec_next  = vectoring;
            x_next    = x_init;
            y_next    = y_init;
            z_next    = z_init;
        end else if (busy_reg) begin
            if (pos) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - a;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + a;
            end
            iter_next = iter_reg + ITW'(1);
            if (iter_reg == ITW'(STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
        vec_reg <= vec_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

    assign busy  = busy_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

/* hw/rtl/fhm_ctrl.sv */
module fhm_ctrl import fhm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  fhm_status_t status,
    output fhm_cmd_t    cmd
);

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_PREP  = 14'b00000000000010,
        ST_DIV1  = 14'b00000000000100,
        ST_RMUL  = 14'b00000000001000,
        ST_DIV2S = 14'b00000000010000,
        ST_DIV2  = 14'b00000000100000,
        ST_HEAD  = 14'b00000001000000,
        ST_IDX   = 14'b00000010000000,
        ST_ANG   = 14'b00000100000000,
        ST_ROT   = 14'b00001000000000,
        ST_MIX1  = 14'b00010000000000,
        ST_MIX2  = 14'b00100000000000,
        ST_MIX3  = 14'b01000000000000,
        ST_DONE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV1;
            end
            ST_DIV1: begin
                if (!status.div_busy) begin
                    state_next = ST_RMUL;
                end
            end
            ST_RMUL: begin
                cmd.rmul   = 1'b1;
                state_next = ST_DIV2S;
            end
            ST_DIV2S: begin
                cmd.div2_start = 1'b1;
                state_next     = ST_DIV2;
            end
            ST_DIV2: begin
                if (!status.div_busy) begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                cmd.head   = 1'b1;
                state_next = ST_IDX;
            end
            ST_IDX: begin
                cmd.idx    = 1'b1;
                state_next = ST_ANG;
            end
            ST_ANG: begin
                cmd.ang    = 1'b1;
                state_next = ST_ROT;
            end
            ST_ROT: begin
                if (!status.cordic_busy) begin
                    state_next = ST_MIX1;
                end
            end
            ST_MIX1: begin
                cmd.mix1   = 1'b1;
                state_next = ST_MIX2;
            end
            ST_MIX2: begin
                cmd.mix2   = 1'b1;
                state_next = ST_MIX3;
            end
            ST_MIX3: begin
                cmd.mix3   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

/* hw/rtl/fhm_datapath.sv */
module fhm_datapath import fhm_pkg::*; #(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [159:0] in_data,
    input  logic         in_flag,
    output logic [47:0]  out_data,
    output logic         out_valid,
    input  logic         out_ready,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  fhm_cmd_t     cmd,
    output fhm_status_t  status
);

    localparam int SB   = SINE_TABLE_BITS;
    localparam int SH_R = (SB <= 11) ? (11 - SB) : 0;
    localparam int SH_L = (SB > 11) ? (SB - 11) : 0;

    // configuration
    logic [11:0] rot_gain_reg;
    logic [7:0]  rot_db_reg;
    logic [6:0]  move_db_reg;
    logic [15:0] cpt_reg;
    logic [8:0]  mms_reg, mrs_reg;

    // item state
    logic signed [7:0]  lr_reg, fb_reg, tbf_reg, tlr_reg;
    logic signed [33:0] sum_reg, offset_reg;
    logic               rst_req_reg, diff_neg_reg, neg_reg;
    logic [7:0]         pcap_reg, root_reg;
    logic [15:0]        sq_reg;
    logic [3:0]         rbit_reg;
    logic [32:0]        prod_reg;
    logic [16:0]        hq8_reg;
    logic signed [18:0] jq8_reg;
    logic [36:0]        idxp_reg;
    logic signed [10:0] err_reg;
    logic signed [1:0]  sense_reg;
    logic signed [15:0] s_reg, c_reg;
    logic [8:0]         move_reg, rot_reg;
    logic signed [24:0] lrm_reg, fbm_reg;
    logic signed [33:0] rterm_reg;
    logic signed [37:0] tot_reg [4];
    logic signed [7:0]  drv_reg [4];
    logic [8:0]         head_out_reg;
    logic signed [1:0]  sense_out_reg;
    logic               out_valid_reg;

    logic [15:0] cpt_eff;
    assign cpt_eff = (cpt_reg == 16'd0) ? 16'd1 : cpt_reg;

    function automatic logic signed [15:0] q30_to_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        t = (v + 34'sd16384) >>> 15;
        if (t > 34'sd32767) begin
            return 16'sh7FFF;
        end else if (t < -34'sd32768) begin
            return 16'sh8000;
        end
        return t[15:0];
    endfunction

    function automatic logic signed [7:0] trunc_sat(input logic signed [37:0] v);
        logic signed [37:0] q;
        q = v[37] ? ((v + 38'sd16777215) >>> 24) : (v >>> 24);
        if (q > 38'sd127) begin
            return 8'sd127;
        end else if (q < -38'sd127) begin
            return -8'sd127;
        end
        return q[7:0];
    endfunction

    // ---- shared units
    logic             div_start, div_busy;
    logic [DIV_W-1:0] div_dvd, div_quo;
    logic [15:0]      div_rem;
    logic             cor_start, cor_vec, cor_busy;
    logic signed [CW-1:0] cor_x0, cor_y0, cor_x, cor_y;
    logic signed [ZW-1:0] cor_z0, cor_z;

    // ---- prep: heading difference, stick magnitude squared, atan2 set-up
    logic signed [33:0] diff;
    logic [33:0]        diff_abs;
    logic [16:0]        stick_sq;
    logic signed [CW-1:0] vx, vy;
    logic signed [ZW-1:0] vz;

    always_comb begin
        diff     = sum_reg - offset_reg;
        diff_abs = diff[33] ? 34'(-diff) : 34'(diff);
        stick_sq = 17'(16'(tlr_reg * tlr_reg)) + 17'(16'(tbf_reg * tbf_reg));
        vx       = CW'(tbf_reg) <<< 16;
        vy       = CW'(tlr_reg) <<< 16;
        vz       = '0;
        if (tbf_reg < 0) begin
            vz = (tlr_reg >= 0) ? DEG_Q16_HALF : -DEG_Q16_HALF;
            vx = -vx;
            vy = -vy;
        end
    end

    // ---- turn power: integer square root, one result bit per cycle
    logic [2:0] rbit_pos;
    logic [7:0] root_cand;
    logic       root_fit;
    always_comb begin
        rbit_pos  = 3'(rbit_reg - 4'd1);
        root_cand = root_reg | (8'd1 << rbit_pos);
        root_fit  = (16'(root_cand) * 16'(root_cand)) <= sq_reg;
    end

    // ---- remainder fold: diff mod cpt, kept non-negative
    logic [15:0] r_mod;
    always_comb begin
        r_mod = div_rem;
        if (diff_neg_reg && div_rem != 16'd0) begin
            r_mod = cpt_eff - div_rem;
        end
    end

    // ---- target angle from the vectoring result
    logic signed [ZW-1:0] zr;
    logic signed [18:0]   jq8;
    always_comb begin
        zr  = (cor_z + 27'sd128) >>> 8;
        jq8 = zr[18:0];
        if (zr > 27'sd46080 || zr <= -27'sd46080) begin
            jq8 = 19'sd46080;
        end
        if (tbf_reg == 8'sd0 && tlr_reg == 8'sd0) begin
            jq8 = '0;
        end
    end

    // ---- heading error and table index
    logic [17:0]        idx_t;
    logic signed [19:0] e20, et20;
    always_comb begin
        idx_t = (18'(hq8_reg) >> SH_R) << SH_L;
        e20   = 20'(jq8_reg) - $signed({3'b000, hq8_reg});
        et20  = e20[19] ? ((e20 + 20'sd255) >>> 8) : (e20 >>> 8);
    end

    // ---- sincos set-up, turn sense and power cap
    logic [SB-1:0]        idx_w;
    logic [ZW-1:0]        ang_u;
    logic signed [ZW-1:0] ang, rz0;
    logic                 rneg;
    logic [10:0]          aerr;
    logic [22:0]          lim;
    logic signed [1:0]    sense;
    logic [7:0]           power;
    always_comb begin
        idx_w = idxp_reg[24 +: SB];
        ang_u = (ZW'(idx_w) * ZW'(360)) << (16 - SB);
        ang   = $signed(ang_u);
        rz0   = ang;
        rneg  = 1'b0;
        if (ang > DEG_Q16_QUARTER) begin
            if (ang <= 3 * DEG_Q16_QUARTER) begin
                rz0  = ang - 2 * DEG_Q16_QUARTER;
                rneg = 1'b1;
            end else begin
                rz0  = ang - 4 * DEG_Q16_QUARTER;
            end
        end
        aerr  = err_reg[10] ? 11'(-err_reg) : 11'(err_reg);
        lim   = (23'(rot_gain_reg) * 23'(aerr)) >> 8;
        sense = (err_reg > 0) ? 2'sd1 : ((err_reg < 0) ? -2'sd1 : 2'sd0);
        if (aerr > 11'd180) begin
            sense = -sense;
        end
        power = (root_reg < rot_db_reg) ? 8'd0 : root_reg;
    end

    // ---- shares and Q15 sin/cos
    logic [7:0]           abs_lr, abs_fb;
    logic                 moving, rotating;
    logic signed [CW-1:0] sx, sy;
    always_comb begin
        abs_lr   = lr_reg[7] ? 8'(-lr_reg) : 8'(lr_reg);
        abs_fb   = fb_reg[7] ? 8'(-fb_reg) : 8'(fb_reg);
        moving   = (abs_fb > {1'b0, move_db_reg}) || (abs_lr > {1'b0, move_db_reg});
        rotating = pcap_reg > rot_db_reg;
        sx       = neg_reg ? -cor_x : cor_x;
        sy       = neg_reg ? -cor_y : cor_y;
    end

    // ---- mixing
    logic [16:0]        pr;
    logic signed [17:0] prs;
    logic signed [25:0] combo [4];
    logic signed [9:0]  mv;
    always_comb begin
        pr       = 17'(pcap_reg) * 17'(rot_reg);
        prs      = (sense_reg == 2'sd1) ? $signed({1'b0, pr}) :
                   ((sense_reg == -2'sd1) ? -$signed({1'b0, pr}) : 18'sd0);
        combo[0] = 26'(lrm_reg) - 26'(fbm_reg);   // front right
        combo[1] = 26'(fbm_reg) + 26'(lrm_reg);   // front left
        combo[2] = 26'(fbm_reg) - 26'(lrm_reg);   // back left
        combo[3] = -26'(fbm_reg) - 26'(lrm_reg);  // back right
        mv       = $signed({1'b0, move_reg});
    end

    assign div_start = cmd.prep || cmd.div2_start;
    assign div_dvd   = cmd.prep ? diff_abs : {1'b0, prod_reg};
    assign cor_start = cmd.prep || cmd.ang;
    assign cor_vec   = cmd.prep;
    assign cor_x0    = cmd.prep ? vx : CORDIC_GAIN_Q30;
    assign cor_y0    = cmd.prep ? vy : '0;
    assign cor_z0    = cmd.prep ? vz : rz0;

    fhm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (cpt_eff),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    fhm_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cor_start),
        .vectoring (cor_vec),
        .x_init    (cor_x0),
        .y_init    (cor_y0),
        .z_init    (cor_z0),
        .busy      (cor_busy),
        .x_out     (cor_x),
        .y_out     (cor_y),
        .z_out     (cor_z)
    );

    // control and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_gain_reg  <= ROTATION_GAIN_RST;
            rot_db_reg    <= ROTATION_DEADBAND_RST;
            move_db_reg   <= MOVE_DEADBAND_RST;
            cpt_reg       <= COUNTS_PER_TURN_RST;
            mms_reg       <= MIX_MOVE_SHARE_RST;
            mrs_reg       <= MIX_ROTATE_SHARE_RST;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
            rbit_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_ROTATION_GAIN:     rot_gain_reg <= cfg_data[11:0];
                    CFG_ROTATION_DEADBAND: rot_db_reg   <= cfg_data[7:0];
                    CFG_MOVE_DEADBAND:     move_db_reg  <= cfg_data[6:0];
                    CFG_COUNTS_PER_TURN:   cpt_reg      <= cfg_data;
                    CFG_MIX_MOVE_SHARE:    mms_reg      <= cfg_data[8:0];
                    CFG_MIX_ROTATE_SHARE:  mrs_reg      <= cfg_data[8:0];
                    default: ;
                endcase
            end
            // offset moves only after this item's difference is taken
            if (cmd.prep && rst_req_reg) begin
                offset_reg <= sum_reg;
            end
            // root bits are settled during the first divider pass
            if (cmd.prep) begin
                rbit_reg <= 4'd8;
            end else if (rbit_reg != 4'd0) begin
                rbit_reg <= rbit_reg - 4'd1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lr_reg      <= in_data[7:0];
            fb_reg      <= in_data[15:8];
            tbf_reg     <= in_data[23:16];
            tlr_reg     <= in_data[31:24];
            sum_reg     <= 34'($signed(in_data[63:32])) + 34'($signed(in_data[95:64]))
                         + 34'($signed(in_data[127:96])) + 34'($signed(in_data[159:128]));
            rst_req_reg <= in_flag;
        end
        if (cmd.prep) begin
            diff_neg_reg <= diff[33];
            sq_reg       <= stick_sq[15:0];
            root_reg     <= '0;
        end else if (rbit_reg != 4'd0 && root_fit) begin
            root_reg <= root_cand;
        end
        if (cmd.rmul) begin
            prod_reg <= 33'(r_mod) * 33'(DEG_Q8_FULL);
        end
        if (cmd.head) begin
            hq8_reg <= div_quo[16:0];
            jq8_reg <= jq8;
        end
        if (cmd.idx) begin
            idxp_reg <= 37'(idx_t) * 37'(RECIP_45_Q24);
            err_reg  <= et20[10:0];
        end
        if (cmd.ang) begin
            neg_reg   <= rneg;
            sense_reg <= sense;
            pcap_reg  <= (23'(power) > lim) ? lim[7:0] : power;
        end
        if (cmd.mix1) begin
            s_reg <= q30_to_q15(sy);
            c_reg <= q30_to_q15(sx);
            if (moving && rotating) begin
                move_reg <= mms_reg;
                rot_reg  <= mrs_reg;
            end else if (rotating) begin
                move_reg <= 9'd0;
                rot_reg  <= 9'd256;
            end else begin
                move_reg <= 9'd256;
                rot_reg  <= 9'd0;
            end
        end
        if (cmd.mix2) begin
            lrm_reg   <= 25'(lr_reg * c_reg) - 25'(fb_reg * s_reg);
            fbm_reg   <= 25'(lr_reg * s_reg) + 25'(fb_reg * c_reg);
            rterm_reg <= 34'(prs) <<< 16;
        end
        if (cmd.mix3) begin
            for (int k = 0; k < 4; k++) begin
                tot_reg[k] <= 38'(rterm_reg) + 38'(combo[k] * mv);
            end
        end
        if (cmd.out_load) begin
            for (int k = 0; k < 4; k++) begin
                drv_reg[k] <= trunc_sat(tot_reg[k]);
            end
            head_out_reg  <= hq8_reg[16:8];
            sense_out_reg <= sense_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = {5'd0, sense_out_reg, head_out_reg,
                        drv_reg[3], drv_reg[2], drv_reg[1], drv_reg[0]};

    assign status.div_busy    = div_busy;
    assign status.cordic_busy = cor_busy;
    assign status.out_free    = !out_valid_reg || out_ready;

endmodule

/* hw/rtl/field_centric_holonomic_mixer_unit.sv */
// Field-oriented X-drive mixer: one result item for each input item, one item
// in flight at a time. The heading needs two passes of a radix-2 divider: the
// encoder difference mod counts_per_turn, then the scaled remainder over
// counts_per_turn. The atan2 CORDIC and the turn-power square root run alongside
// the first pass. A rotation CORDIC for sin/cos then runs, followed by the mixing
// stages. A finished item waits in the output register while the next one is
// taken. If that register is still full when the next result is ready, the block
// waits. heading_reset applies after the item that carries it.
// Configuration writes are taken in any cycle and must only be made while idle.
module field_centric_holonomic_mixer_unit import fhm_pkg::*; #(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // strafe_axis, forward_axis, turn_forward_axis, turn_side_axis (8 each),
    // enc_front_right, enc_front_left, enc_back_left, enc_back_right (32 each)
    input  logic [159:0] s_tdata,
    // heading_reset
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // drive_front_right, drive_front_left, drive_back_left, drive_back_right
    // (8 each), heading_deg (9), turn_sense (2), zero fill (5)
    output logic [47:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    fhm_cmd_t    cmd;
    fhm_status_t status;

    fhm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fhm_datapath #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_tdata),
        .in_flag   (s_tuser[0]),
        .out_data  (m_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

`include "assert_macros.svh"

    `FHM_ASSERT_IMP(a_div_idle_on_start, aclk, aresetn, cmd.prep || cmd.div2_start, !status.div_busy, "divider restarted while busy")
    `FHM_ASSERT_IMP(a_atan_done_at_head, aclk, aresetn, cmd.head, !status.cordic_busy, "atan2 not finished when heading is formed")
    `FHM_ASSERT_IMP(a_cordic_idle_on_rot, aclk, aresetn, cmd.ang, !status.cordic_busy, "sincos started while CORDIC busy")
    `FHM_ASSERT_IMP(a_out_free_on_load, aclk, aresetn, cmd.out_load, status.out_free, "result overwrites an item not yet taken")
    `FHM_ASSERT(a_one_item_in_flight, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "second item taken while one is in flight")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import fhm_pkg::*;

    localparam int SIN_BITS   = 9;
    localparam int ATAN_STEPS = 16;
    localparam longint FULL_Q8 = 92160;
    localparam longint HALF_Q8 = 46080;
    localparam longint QTR_Q16 = 5898240;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic              heading_reset;
        logic signed [31:0] enc_br;
        logic signed [31:0] enc_bl;
        logic signed [31:0] enc_fl;
        logic signed [31:0] enc_fr;
        logic signed [7:0]  turn_side;
        logic signed [7:0]  turn_fwd;
        logic signed [7:0]  forward;
        logic signed [7:0]  strafe;
    } stick_item_t;

    typedef struct packed {
        logic signed [1:0] sense;
        logic [8:0]        heading;
        logic signed [7:0] br;
        logic signed [7:0] bl;
        logic signed [7:0] fl;
        logic signed [7:0] fr;
    } drive_cmd_t;

    typedef struct {
        stick_item_t it;
        bit          typed;
        drive_cmd_t  want;
    } drive_row_t;

    typedef struct {
        int gain, rdb, mdb, cpt, mms, mrs;
        int send_idle, recv_idle, count;
        bit squeeze;
    } phase_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    field_centric_holonomic_mixer_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    longint atan_tab [ATAN_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    // mirrored configuration and heading offset
    longint gain_q8, rot_db, move_db, cpt_reg, move_share, rot_share;
    longint heading_offset;

    drive_cmd_t pending_cmds[$];
    int errors = 0;
    int items_sent = 0;
    int cmds_seen = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int hold_token = 0;

    function automatic longint angle_of(longint y_in, longint x_in);
        longint x, y, z, nx, ny, r;
        x = x_in * 65536;
        y = y_in * 65536;
        z = 0;
        if (x_in == 0 && y_in == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ATAN_STEPS; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += atan_tab[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= atan_tab[i];
            end
            x = nx;
            y = ny;
        end
        r = (z + 128) >>> 8;
        if (r > HALF_Q8 || r <= -HALF_Q8) r = HALF_Q8;
        return r;
    endfunction

    function automatic longint to_q15(longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r < -32768) r = -32768;
        if (r > 32767) r = 32767;
        return r;
    endfunction

    task automatic sin_cos(input longint ang, output longint s, output longint c);
        longint x, y, z, nx, ny;
        bit flip;
        x = 652032875;
        y = 0;
        z = ang;
        flip = 0;
        if (z > QTR_Q16) begin
            if (z <= 3 * QTR_Q16) begin
                z -= 2 * QTR_Q16;
                flip = 1;
            end else begin
                z -= 4 * QTR_Q16;
            end
        end
        for (int i = 0; i < ATAN_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= atan_tab[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += atan_tab[i];
            end
            x = nx;
            y = ny;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = to_q15(y);
        c = to_q15(x);
    endtask

    function automatic longint clip127(longint v);
        return v < -127 ? -127 : (v > 127 ? 127 : v);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic mix_drive(input stick_item_t it, output drive_cmd_t r);
        longint lr, fb, tbf, tlr, sum, cpt, diff, num, hq8, jq8, pw, err, sense, lim;
        longint s, c, lrm, fbm, idx, mv, rt, rterm;
        longint cmb [4];
        logic [33:0] d34;
        lr  = $signed(it.strafe);
        fb  = $signed(it.forward);
        tbf = $signed(it.turn_fwd);
        tlr = $signed(it.turn_side);
        sum = longint'($signed(it.enc_fr)) + longint'($signed(it.enc_fl))
            + longint'($signed(it.enc_bl)) + longint'($signed(it.enc_br));
        cpt = (cpt_reg == 0) ? 1 : cpt_reg;
        d34 = 34'(sum - heading_offset);
        diff = $signed(d34);
        num = diff * FULL_Q8;
        hq8 = num / cpt;
        if (num % cpt != 0 && num < 0) hq8--;
        hq8 = hq8 % FULL_Q8;
        if (hq8 < 0) hq8 += FULL_Q8;

        jq8 = angle_of(tlr, tbf);
        pw = 0;
        while ((pw + 1) * (pw + 1) <= tlr * tlr + tbf * tbf) pw++;
        if (pw < rot_db) pw = 0;

        err = (jq8 - hq8) / 256;
        sense = err > 0 ? 1 : (err < 0 ? -1 : 0);
        if (mag(err) > 180) sense = -sense;   // long way round: turn the other way
        lim = (gain_q8 * mag(err)) >>> 8;
        if (pw > lim) pw = lim;

        idx = (hq8 << SIN_BITS) / FULL_Q8;
        sin_cos(idx * (longint'(360) << (16 - SIN_BITS)), s, c);
        lrm = lr * c - fb * s;
        fbm = lr * s + fb * c;

        mv = 256;
        rt = 0;
        if ((mag(fb) > move_db || mag(lr) > move_db) && pw > rot_db) begin
            mv = move_share;
            rt = rot_share;
        end else if (pw > rot_db) begin
            mv = 0;
            rt = 256;
        end
        cmb[0] = lrm - fbm;
        cmb[1] = fbm + lrm;
        cmb[2] = fbm - lrm;
        cmb[3] = -fbm - lrm;
        rterm = pw * sense * rt * 65536;
        r.fr = 8'(clip127((rterm + cmb[0] * mv) / (longint'(1) << 24)));
        r.fl = 8'(clip127((rterm + cmb[1] * mv) / (longint'(1) << 24)));
        r.bl = 8'(clip127((rterm + cmb[2] * mv) / (longint'(1) << 24)));
        r.br = 8'(clip127((rterm + cmb[3] * mv) / (longint'(1) << 24)));
        r.heading = 9'(hq8 >> 8);
        r.sense = 2'(sense);
        if (it.heading_reset) heading_offset = sum;
    endtask

    task automatic send_item(input stick_item_t it, input bit typed, input drive_cmd_t want);
        drive_cmd_t exp_cmd;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it[159:0];
        s_tuser  <= it.heading_reset;
        do @(posedge aclk); while (!s_tready);
        mix_drive(it, exp_cmd);
        pending_cmds.push_back(typed ? want : exp_cmd);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[15:0];
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ROTATION_GAIN:     gain_q8    = val & 12'hFFF;
            CFG_ROTATION_DEADBAND: rot_db     = val & 8'hFF;
            CFG_MOVE_DEADBAND:     move_db    = val & 7'h7F;
            CFG_COUNTS_PER_TURN:   cpt_reg    = val & 16'hFFFF;
            CFG_MIX_MOVE_SHARE:    move_share = val & 9'h1FF;
            CFG_MIX_ROTATE_SHARE:  rot_share  = val & 9'h1FF;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic signed [7:0] rand_axis();
        case ($urandom_range(3))
            0: return 8'($signed($urandom_range(60)) - 30);
            1: begin
                case ($urandom_range(3))
                    0: return 8'sd127;
                    1: return -8'sd127;
                    2: return -8'sd128;
                    default: return 8'sd0;
                endcase
            end
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic signed [31:0] rand_enc(int span);
        if ($urandom_range(9) < 2) return $urandom;
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    function automatic stick_item_t rand_item();
        stick_item_t it;
        int span;
        span = (cpt_reg < 64) ? 64 : int'(cpt_reg);
        it.strafe    = rand_axis();
        it.forward   = rand_axis();
        it.turn_fwd  = rand_axis();
        it.turn_side = rand_axis();
        it.enc_fr    = rand_enc(span);
        it.enc_fl    = rand_enc(span);
        it.enc_bl    = rand_enc(span);
        it.enc_br    = rand_enc(span);
        it.heading_reset = ($urandom_range(99) < 8);
        return it;
    endfunction

    function automatic stick_item_t mk(int lr, int fb, int tf, int ts,
                                       int e0, int e1, int e2, int e3, bit hr);
        stick_item_t it;
        it.strafe = 8'(lr); it.forward = 8'(fb); it.turn_fwd = 8'(tf); it.turn_side = 8'(ts);
        it.enc_fr = e0; it.enc_fl = e1; it.enc_bl = e2; it.enc_br = e3;
        it.heading_reset = hr;
        return it;
    endfunction

    // receiver: random stalls plus an occasional long hold-off
    int hold_seen = 0;
    int hold_left = 0;
    always @(negedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= 400;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        drive_cmd_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[42:0];
            cmds_seen++;
            if (pending_cmds.size() == 0) begin
                $error("unexpected result item %h", m_tdata);
                errors++;
            end else begin
                want = pending_cmds.pop_front();
                if (got.fr != want.fr) begin
                    $error("drive_front_right exp %0d got %0d", want.fr, got.fr); errors++;
                end
                if (got.fl != want.fl) begin
                    $error("drive_front_left exp %0d got %0d", want.fl, got.fl); errors++;
                end
                if (got.bl != want.bl) begin
                    $error("drive_back_left exp %0d got %0d", want.bl, got.bl); errors++;
                end
                if (got.br != want.br) begin
                    $error("drive_back_right exp %0d got %0d", want.br, got.br); errors++;
                end
                if (got.heading != want.heading) begin
                    $error("heading_deg exp %0d got %0d", want.heading, got.heading);
                    errors++;
                end
                if (got.sense != want.sense) begin
                    $error("turn_sense exp %0d got %0d", want.sense, got.sense); errors++;
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        drive_row_t rows[$];
        phase_t phases[$];
        drive_row_t row;
        phase_t ph;
        drive_cmd_t zero_cmd;

        zero_cmd = '0;
        gain_q8 = 486; rot_db = 18; move_db = 25; cpt_reg = 15400;
        move_share = 192; rot_share = 64; heading_offset = 0;

        // directed rows; only the all-quiet ones carry a typed answer
        rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_cmd});
        rows.push_back('{mk(0, 0, 0, 0, 100, -100, 7, -7, 0), 1, zero_cmd});
        rows.push_back('{mk(127, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_cmd});
        rows.push_back('{mk(0, -128, 0, 0, 0, 0, 0, 0, 0), 0, zero_cmd});
        rows.push_back('{mk(-127, 127, 127, 0, 0, 0, 0, 0, 0), 0, zero_cmd});
        rows.push_back('{mk(0, 0, 0, 127, 0, 0, 0, 0, 0), 0, zero_cmd});
        rows.push_back('{mk(0, 0, -127, 0, 0, 0, 0, 0, 0), 0, zero_cmd});
        rows.push_back('{mk(0, 0, -128, -128, 0, 0, 0, 0, 0), 0, zero_cmd});
        rows.push_back('{mk(30, 0, 18, 0, 0, 0, 0, 0, 0), 0, zero_cmd});   // deadband ties
        rows.push_back('{mk(25, 25, 19, 0, 0, 0, 0, 0, 0), 0, zero_cmd});
        rows.push_back('{mk(60, 60, 0, 100, 3000, 2000, 1000, 500, 0), 0, zero_cmd});
        // heading near 350 degrees, target 90: the long way round
        rows.push_back('{mk(0, 0, 0, 127, 15000, 0, 0, 0, 0), 0, zero_cmd});
        rows.push_back('{mk(40, -90, 90, -90, 'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF,
                            'h7FFFFFFF, 0), 0, zero_cmd});
        rows.push_back('{mk(-90, 40, -90, 90, 'h80000000, 'h80000000, 'h80000000,
                            'h80000000, 1), 0, zero_cmd});
        rows.push_back('{mk(50, 50, 50, 50, 'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF,
                            'h7FFFFFFF, 0), 0, zero_cmd});   // 34-bit wrap of the difference
        rows.push_back('{mk(10, 100, 0, 0, 4000, 4000, 0, 0, 1), 0, zero_cmd});
        rows.push_back('{mk(10, 100, 127, 127, 4000, 4000, 0, 0, 0), 0, zero_cmd});
        rows.push_back('{mk(-128, -128, 100, -100, -3850, 0, 0, 0, 0), 0, zero_cmd});

        phases.push_back('{486, 18, 25, 15400, 192, 64, 0, 0, 150, 0});
        phases.push_back('{486, 18, 25, 15400, 192, 64, 81, 0, 200, 0});
        phases.push_back('{486, 18, 25, 15400, 192, 64, 0, 81, 200, 1});
        phases.push_back('{486, 18, 25, 15400, 192, 64, 33, 33, 200, 0});
        phases.push_back('{4095, 0, 0, 1, 256, 256, 0, 0, 200, 1});
        phases.push_back('{0, 255, 127, 65535, 0, 0, 81, 0, 200, 0});
        phases.push_back('{2000, 180, 10, 0, 511, 511, 0, 81, 200, 0});
        phases.push_back('{300, 5, 60, 360, 128, 300, 33, 33, 200, 0});

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[i]) begin
            row = rows[i];
            send_item(row.it, row.typed, row.want);
        end
        s_tvalid <= 1'b0;
        drain();

        foreach (phases[p]) begin
            ph = phases[p];
            write_reg(CFG_ROTATION_GAIN, ph.gain);
            write_reg(CFG_ROTATION_DEADBAND, ph.rdb);
            write_reg(CFG_MOVE_DEADBAND, ph.mdb);
            write_reg(CFG_COUNTS_PER_TURN, ph.cpt);
            write_reg(CFG_MIX_MOVE_SHARE, ph.mms);
            write_reg(CFG_MIX_ROTATE_SHARE, ph.mrs);
            cfg_valid <= 1'b0;
            send_idle = ph.send_idle;
            recv_idle = ph.recv_idle;
            if (ph.squeeze) hold_token++;
            for (int n = 0; n < ph.count; n++)
                send_item(rand_item(), 0, zero_cmd);
            s_tvalid <= 1'b0;
            drain();
        end

        $display("Ran %0d stick items through %0d register settings, %0d commands checked.",
                 items_sent, phases.size() + 1, cmds_seen);
        $display("Stalls on both sides, long receiver hold-offs and heading resets included.");
        if (errors == 0 && pending_cmds.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/fhm_pkg.sv
hw/rtl/fhm_div.sv
hw/rtl/fhm_cordic.sv
hw/rtl/fhm_ctrl.sv
hw/rtl/fhm_datapath.sv
hw/rtl/field_centric_holonomic_mixer_unit.sv
tb/sv/testbench.sv
